// ===== hdl/lmcr_pkg.sv =====
`timescale 1ns / 1ps
package lmcr_pkg;

    localparam logic [2:0] REQ_WRITE  = 3'd0;
    localparam logic [2:0] REQ_RENDER = 3'd1;
    localparam logic [2:0] REQ_CLEAR  = 3'd2;
    localparam logic [2:0] REQ_INIT   = 3'd3;
    localparam logic [2:0] REQ_BRIGHT = 3'd4;

    localparam logic [1:0] CFG_MODULE_COUNT = 2'd0;
    localparam logic [1:0] CFG_MIRROR       = 2'd1;
    localparam logic [1:0] CFG_BRIGHTNESS   = 2'd2;

    localparam logic [7:0] ADDR_ROW0      = 8'd1;
    localparam logic [7:0] ADDR_DECODE    = 8'd9;
    localparam logic [7:0] ADDR_INTENSITY = 8'd10;
    localparam logic [7:0] ADDR_SCANLIM   = 8'd11;
    localparam logic [7:0] ADDR_SHUTDOWN  = 8'd12;
    localparam logic [7:0] ADDR_TEST      = 8'd15;

    localparam logic [2:0] FRAMES_ROWS   = 3'd7;
    localparam logic [2:0] FRAMES_INIT   = 3'd5;
    localparam logic [2:0] FRAMES_BRIGHT = 3'd0;

    typedef logic [7:0][7:0] t_rows;

    typedef struct packed {
        logic       wr_en;
        logic [5:0] wr_addr;
        logic [7:0] wr_data;
        logic       clear;
        logic [5:0] rd_addr;
    } t_store_req;

    function automatic logic [15:0] init_word(input logic [2:0] frame,
                                              input logic [3:0] level);
        logic [15:0] w;
        case (frame)
            3'd0:    w = {ADDR_SHUTDOWN, 8'h00};
            3'd1:    w = {ADDR_TEST, 8'h00};
            3'd2:    w = {ADDR_SCANLIM, 8'h07};
            3'd3:    w = {ADDR_DECODE, 8'h00};
            3'd4:    w = {ADDR_INTENSITY, 4'h0, level};
            3'd5:    w = {ADDR_SHUTDOWN, 8'h01};
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/lmcr_store.sv =====
`timescale 1ns / 1ps
module lmcr_store #(
    parameter int DEPTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lmcr_pkg::t_store_req  i_req,
    output logic [7:0]            o_rd_data
);
    localparam int AW = $clog2(DEPTH);

    logic [7:0]       r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_vld[i_req.rd_addr[AW-1:0]] ? r_mem[i_req.rd_addr[AW-1:0]] : 8'h00;
    end

endmodule

// ===== hdl/lmcr_rotator.sv =====
`timescale 1ns / 1ps
module lmcr_rotator (
    input  logic                i_clk,
    input  logic                i_shift,
    input  logic [7:0]          i_col,
    output lmcr_pkg::t_rows     o_rows
);
    lmcr_pkg::t_rows r_rows;

    // shift each column bit into its row; column 0 ends up in bit 7
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int j = 0; j < 8; j++) begin
                r_rows[j] <= {r_rows[j][6:0], i_col[j]};
            end
        end
    end

    assign o_rows = r_rows;

endmodule

// ===== hdl/led_matrix_column_renderer.sv =====
`timescale 1ns / 1ps
// Column renderer for a chain of cascaded 8x8 LED matrix driver chips.
// Command channel: a request transfers at a clock edge with i_start high and
// o_busy low. Write requests update the column store and leave the block idle.
// Render reads the module's 8 columns from the store (one per cycle)
// and then sends 8 frames; clear, init and brightness send 8, 6 and 1 frames.
// A frame is one word per chip, chip 0 first; o_frame_end marks its last word
// and o_last marks the final word of the request.
// Result words leave one per cycle on o_spi_word with o_valid high for one
// cycle each; the receiver cannot stall them. Each word is registered from
// the emit state; render first loads the columns. A request keeps o_busy
// high until its last word, so no new request is taken before then; this is
// set by the single word sequencer that emits one word per cycle.
// Config channel: i_cfg_valid with o_cfg_ready (always high) writes register
// i_cfg_index: 0 module_count, 1 mirror_enable, 2 brightness.
// Reset (synchronous, active low) clears the column store, sets module_count
// to 1 and the other registers to 0, and returns the sequencer to idle.
module led_matrix_column_renderer #(
    parameter int MAX_MODULES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_req_type,
    input  logic [5:0]  i_column_index,
    input  logic [7:0]  i_column_bits,
    input  logic [2:0]  i_module_index,
    output logic        o_valid,
    output logic [15:0] o_spi_word,
    output logic        o_frame_end,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    localparam int DEPTH = MAX_MODULES * 8;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [3:0] r_module_count;
    logic       r_mirror;
    logic [3:0] r_brightness;

    logic [1:0] r_state, n_state;
    logic [2:0] r_req, n_req;
    logic [2:0] r_mod, n_mod;
    logic [3:0] r_cnt, n_cnt;
    logic [2:0] r_frame, n_frame;
    logic [2:0] r_chip, n_chip;
    logic [2:0] r_last_frame, n_last_frame;
    logic       r_rd_pend;

    logic        r_valid, n_valid;
    logic [15:0] r_word, n_word;
    logic        r_frame_end, n_frame_end;
    logic        r_last, n_last;

    logic                 chain_ok;
    logic                 accept;
    logic [2:0]           target;
    logic [2:0]           digit;
    logic                 chip_end;
    logic [7:0]           rd_data;
    lmcr_pkg::t_rows      rows;
    lmcr_pkg::t_store_req store_req;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_count <= 4'd1;
            r_mirror       <= 1'b0;
            r_brightness   <= 4'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                lmcr_pkg::CFG_MODULE_COUNT: r_module_count <= i_cfg_data;
                lmcr_pkg::CFG_MIRROR:       r_mirror       <= i_cfg_data[0];
                lmcr_pkg::CFG_BRIGHTNESS:   r_brightness   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign chain_ok = (r_module_count != 4'd0) && (r_module_count <= 4'(MAX_MODULES));
    assign accept   = i_start && !o_busy;
    assign target   = r_mirror ? 3'(r_module_count - 4'd1 - {1'b0, r_mod}) : r_mod;
    assign digit    = r_mirror ? 3'(3'd7 - r_frame) : r_frame;
    assign chip_end = ({1'b0, r_chip} == (r_module_count - 4'd1));

    always_comb begin
        store_req.wr_en   = 1'b0;
        store_req.wr_addr = i_column_index;
        store_req.wr_data = i_column_bits;
        store_req.clear   = 1'b0;
        store_req.rd_addr = {r_mod, r_cnt[2:0]};

        n_state      = r_state;
        n_req        = r_req;
        n_mod        = r_mod;
        n_cnt        = r_cnt;
        n_frame      = r_frame;
        n_chip       = r_chip;
        n_last_frame = r_last_frame;

        n_valid     = 1'b0;
        n_word      = r_word;
        n_frame_end = r_frame_end;
        n_last      = r_last;

        case (r_state)
            ST_IDLE: begin
                n_frame = 3'd0;
                n_chip  = 3'd0;
                n_cnt   = 4'd0;
                n_req   = i_req_type;
                n_mod   = i_module_index;
                if (accept && chain_ok) begin
                    case (i_req_type)
                        lmcr_pkg::REQ_WRITE: begin
                            store_req.wr_en = ({1'b0, i_column_index}
                                               < {r_module_count, 3'b000});
                        end
                        lmcr_pkg::REQ_RENDER: begin
                            if ({1'b0, i_module_index} < r_module_count) begin
                                n_state      = ST_LOAD;
                                n_last_frame = lmcr_pkg::FRAMES_ROWS;
                            end
                        end
                        lmcr_pkg::REQ_CLEAR: begin
                            store_req.clear = 1'b1;
                            n_state         = ST_EMIT;
                            n_last_frame    = lmcr_pkg::FRAMES_ROWS;
                        end
                        lmcr_pkg::REQ_INIT: begin
                            n_state      = ST_EMIT;
                            n_last_frame = lmcr_pkg::FRAMES_INIT;
                        end
                        lmcr_pkg::REQ_BRIGHT: begin
                            n_state      = ST_EMIT;
                            n_last_frame = lmcr_pkg::FRAMES_BRIGHT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD: begin
                if (r_cnt == 4'd8) begin
                    n_state = ST_EMIT;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_EMIT: begin
                n_valid     = 1'b1;
                n_frame_end = chip_end;
                n_last      = chip_end && (r_frame == r_last_frame);
                case (r_req)
                    lmcr_pkg::REQ_RENDER: begin
                        n_word = (r_chip == target)
                               ? {8'(lmcr_pkg::ADDR_ROW0 + {5'b0, digit}), rows[r_frame]}
                               : 16'h0000;
                    end
                    lmcr_pkg::REQ_CLEAR: begin
                        n_word = {8'(lmcr_pkg::ADDR_ROW0 + {5'b0, r_frame}), 8'h00};
                    end
                    lmcr_pkg::REQ_BRIGHT: begin
                        n_word = {lmcr_pkg::ADDR_INTENSITY, 4'h0, r_brightness};
                    end
                    default: begin
                        n_word = lmcr_pkg::init_word(r_frame, r_brightness);
                    end
                endcase
                if (chip_end) begin
                    n_chip = 3'd0;
                    if (r_frame == r_last_frame) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_frame = r_frame + 3'd1;
                    end
                end else begin
                    n_chip = r_chip + 3'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_valid   <= n_valid;
            r_rd_pend <= (r_state == ST_LOAD) && (r_cnt != 4'd8);
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_mod        <= n_mod;
        r_cnt        <= n_cnt;
        r_frame      <= n_frame;
        r_chip       <= n_chip;
        r_last_frame <= n_last_frame;
        r_word       <= n_word;
        r_frame_end  <= n_frame_end;
        r_last       <= n_last;
    end

    lmcr_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    lmcr_rotator u_rotator (
        .i_clk   (i_clk),
        .i_shift (r_rd_pend),
        .i_col   (rd_data),
        .o_rows  (rows)
    );

    assign o_busy      = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_spi_word  = r_word;
    assign o_frame_end = r_frame_end;
    assign o_last      = r_last;

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_EMIT))
        else $error("word strobed without emit state");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> o_frame_end)
        else $error("last word not at frame end");

    a_render_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && chain_ok && (i_req_type == lmcr_pkg::REQ_RENDER)
         && ({1'b0, i_module_index} < r_module_count)) |=> (r_state == ST_LOAD))
        else $error("render transfer did not start column load");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> !o_valid)
        else $error("word strobed during column load");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> (r_state == ST_IDLE))
        else $error("sequencer still busy after last word");

endmodule
